@@ hw/rtl/tlaik_pkg.sv @@
// Shared constants, types and tables for the three-link arm inverse kinematics core.
// No dependencies; imported by tlaik_atan2 and the top level.
`default_nettype none

package tlaik_pkg;

	// CORDIC depth and derived sizes
	localparam int CORDIC_STAGES = 16;
	localparam int CORDIC_ITERS  = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
	localparam int ATAN_LAT      = CORDIC_ITERS + 4;

	localparam int AT_IN_W = 50;   // atan2 operand width
	localparam int NORM_W  = 31;   // normalized magnitude, below 2^30
	localparam int CX_W    = 34;   // CORDIC x/y datapath
	localparam int ANG_W   = 28;   // angle in 2^-24 rad

	// digit-by-digit square root, 58-bit radicand
	localparam int SQ_IN_W   = 58;
	localparam int SQ_STAGES = SQ_IN_W / 2;

	typedef logic signed [AT_IN_W-1:0] at_in_t;
	typedef logic signed [ANG_W-1:0]   ang_t;

	localparam ang_t PI_Q24 = 28'sd52707179;

	localparam logic [23:0] ATAN_Q24 [24] = '{
		24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
		24'd1047214,  24'd524117,  24'd262123,  24'd131069,
		24'd65536,    24'd32768,   24'd16384,   24'd8192,
		24'd4096,     24'd2048,    24'd1024,    24'd512,
		24'd256,      24'd128,     24'd64,      24'd32,
		24'd16,       24'd8,       24'd4,       24'd2
	};

	// joint limits on raw angles, 1/4096 rad
	localparam int J1_LO = -6434;
	localparam int J1_HI = 12868;
	localparam int J2_LO = -1569;
	localparam int J2_HI = 8507;
	localparam int J3_LO = -10928;
	localparam int J3_HI = 10789;

	// result status
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNREACH = 2'd1;
	localparam logic [1:0] ST_LIMIT   = 2'd2;

	// register map (word index)
	localparam logic [2:0] REG_BASE_HEIGHT = 3'd0;
	localparam logic [2:0] REG_UPPER_LINK  = 3'd1;
	localparam logic [2:0] REG_LOWER_LINK  = 3'd2;
	localparam logic [2:0] REG_J2_OFFSET   = 3'd3;
	localparam logic [2:0] REG_J3_OFFSET   = 3'd4;

	localparam logic [13:0]        BASE_HEIGHT_RST = 14'd1606;
	localparam logic [13:0]        UPPER_LINK_RST  = 14'd2179;
	localparam logic [13:0]        LOWER_LINK_RST  = 14'd1917;
	localparam logic signed [15:0] J2_OFFSET_RST   = 16'sd8507;
	localparam logic signed [15:0] J3_OFFSET_RST   = -16'sd10789;

endpackage

`default_nettype wire

@@ hw/rtl/tlaik_atan2.sv @@
// Pipelined atan2: magnitude, normalization to [2^29, 2^30), CORDIC vectoring, quadrant fix.
// Depends on tlaik_pkg. The pipeline advances only when en is high.
`default_nettype none

module tlaik_atan2 (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire tlaik_pkg::at_in_t y_in,
	input  wire tlaik_pkg::at_in_t x_in,
	output tlaik_pkg::ang_t       angle
);
	import tlaik_pkg::*;

	// stage 1: magnitudes
	logic [AT_IN_W-1:0] ax_s1, ay_s1;
	logic               xneg_s1, yneg_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			xneg_s1 <= x_in[AT_IN_W-1];
			yneg_s1 <= y_in[AT_IN_W-1];
			ax_s1   <= x_in[AT_IN_W-1] ? AT_IN_W'(-x_in) : AT_IN_W'(x_in);
			ay_s1   <= y_in[AT_IN_W-1] ? AT_IN_W'(-y_in) : AT_IN_W'(y_in);
		end
	end

	// stage 2: leading one of the larger magnitude
	logic [AT_IN_W-1:0] mag_c;
	logic [5:0]         pos_c;
	logic [AT_IN_W-1:0] ax_s2, ay_s2;
	logic [5:0]         pos_s2;
	logic               xneg_s2, yneg_s2, zero_s2;

	always_comb begin
		mag_c = (ax_s1 > ay_s1) ? ax_s1 : ay_s1;
		pos_c = '0;
		for (int b = 0; b < AT_IN_W; b++) begin
			if (mag_c[b]) pos_c = 6'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			pos_s2  <= pos_c;
			zero_s2 <= (mag_c == '0);
			xneg_s2 <= xneg_s1;
			yneg_s2 <= yneg_s1;
		end
	end

	// stage 3: normalize, then CORDIC iterations
	logic [AT_IN_W-1:0]   axn_c, ayn_c;
	logic signed [CX_W-1:0] cx_c [CORDIC_ITERS+1];
	logic signed [CX_W-1:0] cy_c [CORDIC_ITERS+1];
	ang_t                   z_c  [CORDIC_ITERS+1];
	logic                   xneg_c [CORDIC_ITERS+1];
	logic                   yneg_c [CORDIC_ITERS+1];
	logic                   zero_c [CORDIC_ITERS+1];

	always_comb begin
		if (pos_s2 >= 6'd30) begin
			axn_c = ax_s2 >> (pos_s2 - 6'd29);
			ayn_c = ay_s2 >> (pos_s2 - 6'd29);
		end else begin
			axn_c = ax_s2 << (6'd29 - pos_s2);
			ayn_c = ay_s2 << (6'd29 - pos_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_c[0]   <= $signed({{(CX_W-NORM_W){1'b0}}, axn_c[NORM_W-1:0]});
			cy_c[0]   <= $signed({{(CX_W-NORM_W){1'b0}}, ayn_c[NORM_W-1:0]});
			z_c[0]    <= '0;
			xneg_c[0] <= xneg_s2;
			yneg_c[0] <= yneg_s2;
			zero_c[0] <= zero_s2;
		end
	end

	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
		localparam ang_t STEP = $signed({{(ANG_W-24){1'b0}}, ATAN_Q24[i]});
		always_ff @(posedge clk) begin
			if (en) begin
				if (cy_c[i] > 0) begin
					cx_c[i+1] <= cx_c[i] + (cy_c[i] >>> i);
					cy_c[i+1] <= cy_c[i] - (cx_c[i] >>> i);
					z_c[i+1]  <= z_c[i] + STEP;
				end else if (cy_c[i] < 0) begin
					cx_c[i+1] <= cx_c[i] - (cy_c[i] >>> i);
					cy_c[i+1] <= cy_c[i] + (cx_c[i] >>> i);
					z_c[i+1]  <= z_c[i] - STEP;
				end else begin
					cx_c[i+1] <= cx_c[i];
					cy_c[i+1] <= cy_c[i];
					z_c[i+1]  <= z_c[i];
				end
				xneg_c[i+1] <= xneg_c[i];
				yneg_c[i+1] <= yneg_c[i];
				zero_c[i+1] <= zero_c[i];
			end
		end
	end

	// quadrant fix: x < 0 mirrors about pi/2, y < 0 negates
	ang_t fix_c, quad_c;

	always_comb begin
		fix_c  = xneg_c[CORDIC_ITERS] ? ang_t'(PI_Q24 - z_c[CORDIC_ITERS]) : z_c[CORDIC_ITERS];
		quad_c = yneg_c[CORDIC_ITERS] ? ang_t'(-fix_c) : fix_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle <= zero_c[CORDIC_ITERS] ? '0 : quad_c;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/three_link_arm_inverse_kinematics_core.sv @@
// Inverse kinematics for a yaw base plus two-link planar arm: target point in, three joint
// angles and a status out. Depends on tlaik_pkg and tlaik_atan2.
`default_nettype none

// One item per cycle while the output buffer has room. Each target passes through a fixed
// pipeline of 4 setup stages, a 29-stage square-root array that computes the elbow sine
// and the planar reach side by side, 2 multiply/add stages, three parallel 20-stage CORDIC
// atan2 units, 2 stages of rounding and limit checks, and the output register. Depth is set
// by the 58-bit square root (one result bit per stage) and the CORDIC stage count. A two-entry
// output buffer (output register plus skid) decouples the consumer: in_ready drops only when
// both entries hold results, and the whole pipeline freezes in place until one is taken.
// Positions are in 1/16384 m, angles in 1/4096 rad. Status 1 marks an unreachable target
// (strict law-of-cosines test), status 2 a raw angle outside the joint limits; both give zero
// angles. Registers sit on an APB port at byte offsets 0x00..0x10, are read back with sign
// extension for the home offsets, and should only be written while no item is in flight.

module three_link_arm_inverse_kinematics_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// APB configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// target item
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] target_x,
	input  wire logic signed [15:0] target_y,
	input  wire logic signed [15:0] target_z,
	input  wire logic [1:0]         solution_index,
	// result item
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      joint1_angle,
	output logic signed [15:0]      joint2_angle,
	output logic signed [15:0]      joint3_angle,
	output logic [1:0]              solution_echo,
	output logic [1:0]              status
);
	import tlaik_pkg::*;

	typedef struct packed {
		logic [1:0]         idx;
		logic               reach;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [16:0] pz;
		logic signed [29:0] n;
		logic signed [30:0] k;
	} sq_meta_t;

	typedef struct packed {
		logic signed [15:0] j1;
		logic signed [15:0] j2;
		logic signed [15:0] j3;
		logic [1:0]         echo;
		logic [1:0]         status;
	} res_t;

	//------------------------------------------------------------------
	// Configuration registers
	//------------------------------------------------------------------
	logic [13:0]        base_height_q, upper_link_q, lower_link_q;
	logic signed [15:0] j2_offset_q, j3_offset_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_height_q <= BASE_HEIGHT_RST;
			upper_link_q  <= UPPER_LINK_RST;
			lower_link_q  <= LOWER_LINK_RST;
			j2_offset_q   <= J2_OFFSET_RST;
			j3_offset_q   <= J3_OFFSET_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_BASE_HEIGHT: base_height_q <= pwdata[13:0];
				REG_UPPER_LINK:  upper_link_q  <= pwdata[13:0];
				REG_LOWER_LINK:  lower_link_q  <= pwdata[13:0];
				REG_J2_OFFSET:   j2_offset_q   <= pwdata[15:0];
				REG_J3_OFFSET:   j3_offset_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_BASE_HEIGHT: prdata = {18'b0, base_height_q};
			REG_UPPER_LINK:  prdata = {18'b0, upper_link_q};
			REG_LOWER_LINK:  prdata = {18'b0, lower_link_q};
			REG_J2_OFFSET:   prdata = 32'(j2_offset_q);
			REG_J3_OFFSET:   prdata = 32'(j3_offset_q);
			default:         prdata = '0;
		endcase
	end

	//------------------------------------------------------------------
	// Pipeline enable: everything advances unless the skid entry is full
	//------------------------------------------------------------------
	logic en;
	logic skid_v_q, out_v_q;

	assign en       = ~skid_v_q;
	assign in_ready = en;

	//------------------------------------------------------------------
	// s1: squares of the target coordinates and link products
	//------------------------------------------------------------------
	logic signed [16:0] pz_c;
	logic signed [31:0] pxsq_c, pysq_c;
	logic signed [33:0] pzsq_c;

	logic               v_s1;
	logic [1:0]         idx_s1;
	logic signed [15:0] px_s1, py_s1;
	logic signed [16:0] pz_s1;
	logic [30:0]        pxsq_s1, pysq_s1;
	logic [31:0]        pzsq_s1;
	logic [27:0]        a2sq_s1, a3sq_s1, a23_s1;

	assign pz_c   = 17'(target_z) - $signed({3'b000, base_height_q});
	assign pxsq_c = target_x * target_x;
	assign pysq_c = target_y * target_y;
	assign pzsq_c = pz_c * pz_c;

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1  <= solution_index;
			px_s1   <= target_x;
			py_s1   <= target_y;
			pz_s1   <= pz_c;
			pxsq_s1 <= pxsq_c[30:0];
			pysq_s1 <= pysq_c[30:0];
			pzsq_s1 <= pzsq_c[31:0];
			a2sq_s1 <= upper_link_q * upper_link_q;
			a3sq_s1 <= lower_link_q * lower_link_q;
			a23_s1  <= upper_link_q * lower_link_q;
		end
	end

	//------------------------------------------------------------------
	// s2: N = |p|^2 - a2^2 - a3^2, D = 2*a2*a3, planar radius squared
	//------------------------------------------------------------------
	logic [33:0]        sum3_c;
	logic               v_s2;
	logic [1:0]         idx_s2;
	logic signed [15:0] px_s2, py_s2;
	logic signed [16:0] pz_s2;
	logic signed [34:0] n_s2;
	logic [28:0]        d_s2;
	logic [31:0]        rxy_s2;

	assign sum3_c = {3'b0, pxsq_s1} + {3'b0, pysq_s1} + {2'b0, pzsq_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s2 <= idx_s1;
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			pz_s2  <= pz_s1;
			n_s2   <= $signed({1'b0, sum3_c}) - $signed({7'b0, a2sq_s1})
				- $signed({7'b0, a3sq_s1});
			d_s2   <= {a23_s1, 1'b0};
			rxy_s2 <= {1'b0, pxsq_s1} + {1'b0, pysq_s1};
		end
	end

	//------------------------------------------------------------------
	// s3: strict reach test, D^2 and N^2, shoulder term K = 2*a2^2 + N
	//------------------------------------------------------------------
	logic signed [34:0] dx_c, nabs_c;
	logic               v_s3, reach_s3;
	logic [1:0]         idx_s3;
	logic signed [15:0] px_s3, py_s3;
	logic signed [16:0] pz_s3;
	logic signed [29:0] n_s3;
	logic signed [30:0] k_s3;
	logic [57:0]        dsq_s3;
	logic [59:0]        nsq_s3;
	logic [31:0]        rxy_s3;

	assign dx_c   = $signed({6'b0, d_s2});
	assign nabs_c = n_s2[34] ? -n_s2 : n_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s3   <= idx_s2;
			px_s3    <= px_s2;
			py_s3    <= py_s2;
			pz_s3    <= pz_s2;
			reach_s3 <= (n_s2 < dx_c) && (-n_s2 < dx_c);
			n_s3     <= n_s2[29:0];
			k_s3     <= $signed({2'b0, a2sq_s1, 1'b0}) + n_s2[30:0];
			dsq_s3   <= d_s2 * d_s2;
			nsq_s3   <= nabs_c[29:0] * nabs_c[29:0];
			rxy_s3   <= rxy_s2;
		end
	end

	//------------------------------------------------------------------
	// s4 + square-root array: lane 0 elbow sine sqrt(D^2 - N^2),
	// lane 1 planar reach sqrt(px^2 + py^2); one root bit per stage
	//------------------------------------------------------------------
	logic [SQ_IN_W-1:0] sq_rad  [2][SQ_STAGES+1];
	logic [30:0]        sq_rem  [2][SQ_STAGES+1];
	logic [28:0]        sq_root [2][SQ_STAGES+1];
	sq_meta_t           sq_meta [SQ_STAGES+1];
	logic               sq_vld  [SQ_STAGES+1];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rad[0][0]  <= dsq_s3 - nsq_s3[57:0];
			sq_rad[1][0]  <= {26'b0, rxy_s3};
			sq_rem[0][0]  <= '0;
			sq_rem[1][0]  <= '0;
			sq_root[0][0] <= '0;
			sq_root[1][0] <= '0;
			sq_meta[0]    <= '{idx: idx_s3, reach: reach_s3, px: px_s3, py: py_s3,
				pz: pz_s3, n: n_s3, k: k_s3};
		end
	end

	for (genvar ln = 0; ln < 2; ln++) begin : g_lane
		for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sq
			logic [32:0] rin_c, trial_c;
			assign rin_c   = {sq_rem[ln][j], sq_rad[ln][j][SQ_IN_W-1 -: 2]};
			assign trial_c = {2'b0, sq_root[ln][j], 2'b01};
			always_ff @(posedge clk) begin
				if (en) begin
					sq_rad[ln][j+1] <= sq_rad[ln][j] << 2;
					if (rin_c >= trial_c) begin
						sq_rem[ln][j+1]  <= 31'(rin_c - trial_c);
						sq_root[ln][j+1] <= {sq_root[ln][j][27:0], 1'b1};
					end else begin
						sq_rem[ln][j+1]  <= 31'(rin_c);
						sq_root[ln][j+1] <= {sq_root[ln][j][27:0], 1'b0};
					end
				end
			end
		end
	end

	for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqm
		always_ff @(posedge clk) begin
			if (en) sq_meta[j+1] <= sq_meta[j];
		end
	end

	//------------------------------------------------------------------
	// s5: signed elbow sine, shoulder numerator products
	//------------------------------------------------------------------
	sq_meta_t           mend;
	logic               neg_c;
	logic signed [29:0] s_c;
	logic signed [16:0] pxy_c;

	logic               v_s5, reach_s5;
	logic [1:0]         idx_s5;
	logic signed [15:0] px_s5, py_s5;
	logic signed [29:0] s_s5, n_s5;
	logic signed [47:0] kpz_s5, kpxy_s5;
	logic signed [46:0] spxy_s5, spz_s5;

	assign mend  = sq_meta[SQ_STAGES];
	assign neg_c = (mend.idx == 2'd1) || (mend.idx == 2'd2);
	assign s_c   = neg_c ? -$signed({1'b0, sq_root[0][SQ_STAGES]})
		: $signed({1'b0, sq_root[0][SQ_STAGES]});
	assign pxy_c = $signed({1'b0, sq_root[1][SQ_STAGES][15:0]});

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s5   <= mend.idx;
			reach_s5 <= mend.reach;
			px_s5    <= mend.px;
			py_s5    <= mend.py;
			s_s5     <= s_c;
			n_s5     <= mend.n;
			kpz_s5   <= mend.k * mend.pz;
			kpxy_s5  <= mend.k * pxy_c;
			spxy_s5  <= s_c * pxy_c;
			spz_s5   <= s_c * mend.pz;
		end
	end

	//------------------------------------------------------------------
	// s6: shoulder atan2 operands
	//------------------------------------------------------------------
	logic               v_s6, reach_s6;
	logic [1:0]         idx_s6;
	logic signed [15:0] px_s6, py_s6;
	logic signed [29:0] s_s6, n_s6;
	logic signed [48:0] y2_s6, x2_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s6   <= idx_s5;
			reach_s6 <= reach_s5;
			px_s6    <= px_s5;
			py_s6    <= py_s5;
			s_s6     <= s_s5;
			n_s6     <= n_s5;
			y2_s6    <= 49'(kpz_s5) - 49'(spxy_s5);
			x2_s6    <= 49'(kpxy_s5) + 49'(spz_s5);
		end
	end

	//------------------------------------------------------------------
	// Three atan2 units in parallel; status bits ride alongside
	//------------------------------------------------------------------
	ang_t a1q, a2q, a3q;

	tlaik_atan2 u_atan_base (
		.clk   (clk),
		.en    (en),
		.y_in  (AT_IN_W'(py_s6)),
		.x_in  (AT_IN_W'(px_s6)),
		.angle (a1q)
	);

	tlaik_atan2 u_atan_shoulder (
		.clk   (clk),
		.en    (en),
		.y_in  (AT_IN_W'(y2_s6)),
		.x_in  (AT_IN_W'(x2_s6)),
		.angle (a2q)
	);

	tlaik_atan2 u_atan_elbow (
		.clk   (clk),
		.en    (en),
		.y_in  (AT_IN_W'(s_s6)),
		.x_in  (AT_IN_W'(n_s6)),
		.angle (a3q)
	);

	logic [1:0] at_idx   [ATAN_LAT+1];
	logic       at_reach [ATAN_LAT+1];
	logic       at_vld   [ATAN_LAT+1];

	assign at_idx[0]   = idx_s6;
	assign at_reach[0] = reach_s6;

	for (genvar j = 0; j < ATAN_LAT; j++) begin : g_atd
		always_ff @(posedge clk) begin
			if (en) begin
				at_idx[j+1]   <= at_idx[j];
				at_reach[j+1] <= at_reach[j];
			end
		end
	end

	//------------------------------------------------------------------
	// s7: arm-space selection, one rounding to 1/4096 rad (halves up)
	//------------------------------------------------------------------
	function automatic logic signed [15:0] rnd_q12(input logic signed [28:0] v);
		logic signed [28:0] r;
		r = v + 29'sd2048;
		return 16'(r >>> 12);
	endfunction

	logic               inv_c;
	logic               v_s7, reach_s7;
	logic [1:0]         idx_s7;
	logic signed [15:0] t1_s7, t2_s7, t3_s7;

	assign inv_c = at_idx[ATAN_LAT][1];

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s7   <= at_idx[ATAN_LAT];
			reach_s7 <= at_reach[ATAN_LAT];
			if (inv_c) begin
				t1_s7 <= rnd_q12(29'(a1q) + 29'(PI_Q24));
				t2_s7 <= rnd_q12(29'(PI_Q24) - 29'(a2q));
				t3_s7 <= rnd_q12(-29'(a3q));
			end else begin
				t1_s7 <= rnd_q12(29'(a1q));
				t2_s7 <= rnd_q12(29'(a2q));
				t3_s7 <= rnd_q12(29'(a3q));
			end
		end
	end

	//------------------------------------------------------------------
	// s8: joint limits, home offsets with saturation, status
	//------------------------------------------------------------------
	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		if (v > 17'sd32767)       return 16'sh7fff;
		else if (v < -17'sd32768) return 16'sh8000;
		else                      return 16'(v);
	endfunction

	logic bad_c;
	logic v_s8;
	res_t res_s8;

	assign bad_c = (t1_s7 < J1_LO) || (t1_s7 > J1_HI) || (t2_s7 < J2_LO)
		|| (t2_s7 > J2_HI) || (t3_s7 < J3_LO) || (t3_s7 > J3_HI);

	always_ff @(posedge clk) begin
		if (en) begin
			res_s8.echo <= idx_s7;
			if (!reach_s7) begin
				res_s8.status <= ST_UNREACH;
				res_s8.j1     <= '0;
				res_s8.j2     <= '0;
				res_s8.j3     <= '0;
			end else if (bad_c) begin
				res_s8.status <= ST_LIMIT;
				res_s8.j1     <= '0;
				res_s8.j2     <= '0;
				res_s8.j3     <= '0;
			end else begin
				res_s8.status <= ST_OK;
				res_s8.j1     <= t1_s7;
				res_s8.j2     <= sat16(17'(t2_s7) - 17'(j2_offset_q));
				res_s8.j3     <= sat16(17'(t3_s7) - 17'(j3_offset_q));
			end
		end
	end

	//------------------------------------------------------------------
	// Valid bits, all stages
	//------------------------------------------------------------------
	for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)  sq_vld[j+1] <= 1'b0;
			else if (en)  sq_vld[j+1] <= sq_vld[j];
		end
	end

	assign at_vld[0] = v_s6;

	for (genvar j = 0; j < ATAN_LAT; j++) begin : g_atv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)  at_vld[j+1] <= 1'b0;
			else if (en)  at_vld[j+1] <= at_vld[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			sq_vld[0] <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			sq_vld[0] <= v_s3;
			v_s5      <= sq_vld[SQ_STAGES];
			v_s6      <= v_s5;
			v_s7      <= at_vld[ATAN_LAT];
			v_s8      <= v_s7;
		end
	end

	//------------------------------------------------------------------
	// Output register plus skid entry
	//------------------------------------------------------------------
	res_t out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!skid_v_q) begin
			if (!out_v_q || out_ready) out_v_q  <= v_s8;
			else if (v_s8)             skid_v_q <= 1'b1;
		end else if (out_ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			if (!out_v_q || out_ready) out_q  <= res_s8;
			else                       skid_q <= res_s8;
		end else if (out_ready) begin
			out_q <= skid_q;
		end
	end

	assign out_valid     = out_v_q;
	assign joint1_angle  = out_q.j1;
	assign joint2_angle  = out_q.j2;
	assign joint3_angle  = out_q.j3;
	assign solution_echo = out_q.echo;
	assign status        = out_q.status;

	//------------------------------------------------------------------
	// Assertions
	//------------------------------------------------------------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry holds an item while the output register is empty");

	a_stall_catch: assert property (@(posedge clk) disable iff (!arst_n)
		(!skid_v_q && v_s8 && out_v_q && !out_ready) |=> skid_v_q)
		else $error("result leaving the pipeline under back-pressure was not captured");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.status != ST_OK) |->
		(out_q.j1 == 16'sd0 && out_q.j2 == 16'sd0 && out_q.j3 == 16'sd0))
		else $error("error result carries nonzero angles");

	a_ok_j1_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.status == ST_OK) |-> (out_q.j1 >= J1_LO && out_q.j1 <= J1_HI))
		else $error("valid result has base angle outside its limits");

endmodule

`default_nettype wire
